@@ rtl/core/knn_sel_pkg.sv @@
`default_nettype none
package knn_sel_pkg;

    localparam int REL_W    = 25;
    localparam int DIST_W   = 26;
    localparam int IDX_W    = 6;
    localparam int OUT_BITS = 9 * REL_W + DIST_W;
    localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8;
    localparam int RANGE2_W = 2 * DIST_W;

    localparam logic [DIST_W-1:0] PAD_DISTANCE = DIST_W'(256000);
    localparam logic [DIST_W-1:0] DIST_MAX     = {DIST_W{1'b1}};

    localparam logic [1:0] CFG_ACTIVE  = 2'd0;
    localparam logic [1:0] CFG_WANTED  = 2'd1;
    localparam logic [1:0] CFG_SHARING = 2'd2;
    localparam logic [1:0] CFG_RANGE   = 2'd3;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic clr;
        logic ins;
    } knn_ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/knn_sel_cell.sv @@
`default_nettype none
module knn_sel_cell #(
    parameter int D2W = 52,
    parameter int AW  = 6
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire knn_sel_pkg::knn_ctl_t ctl,
    input  wire logic [D2W-1:0]      new_d2,
    input  wire logic [AW-1:0]       new_who,
    input  wire logic                prev_take,
    input  wire logic                prev_valid,
    input  wire logic [D2W-1:0]      prev_d2,
    input  wire logic [AW-1:0]       prev_who,
    output logic                     take,
    output logic                     valid,
    output logic [D2W-1:0]           d2,
    output logic [AW-1:0]            who
);
    import knn_sel_pkg::*;

    logic           valid_reg;
    logic [D2W-1:0] d2_reg;
    logic [AW-1:0]  who_reg;

    assign take  = !valid_reg || (new_d2 < d2_reg);
    assign valid = valid_reg;
    assign d2    = d2_reg;
    assign who   = who_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.clr)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.ins && take)
        begin
            valid_reg <= prev_take ? prev_valid : 1'b1;
        end
    end

    // shift down from the neighbor, or drop the new candidate in here
    always_ff @(posedge clk)
    begin
        if (ctl.ins && take)
        begin
            if (prev_take)
            begin
                d2_reg  <= prev_d2;
                who_reg <= prev_who;
            end
            else
            begin
                d2_reg  <= new_d2;
                who_reg <= new_who;
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/knn_sel_isqrt.sv @@
`default_nettype none
module knn_sel_isqrt #(
    parameter int D2W = 52
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [D2W-1:0]      radicand,
    output logic                     done,
    output logic [D2W/2-1:0]         root
);
    import knn_sel_pkg::*;

    localparam int RW = D2W / 2;
    localparam int CW = $clog2(RW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [RW+1:0]   rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [D2W-1:0]  src_reg, src_next;
    logic [RW+1:0]   rem_sh;
    logic [RW+1:0]   trial;

    assign done = done_reg;
    assign root = root_reg;
    assign rem_sh = {rem_reg[RW-1:0], src_reg[D2W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        src_next  = src_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            rem_next  = '0;
            root_next = '0;
            src_next  = radicand;
        end
        else if (busy_reg)
        begin
            src_next = {src_reg[D2W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[RW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(RW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        src_reg  <= src_next;
    end

endmodule
`default_nettype wire

@@ rtl/core/k_nearest_neighbor_select_core.sv @@
// Write request: stored as it is accepted. Query request: the ego entry is read, then the
// active entries are read one per cycle through the table read port, the distance pipeline
// drains, and then each result is read from the table and gets a root (one root bit per cycle) or is padding,
// each held until taken. One request is in work at a time.
// Reset (asynchronous, rst_n low) clears control state and sets the registers to their
// defaults; table contents are undefined until written.
`default_nettype none
module k_nearest_neighbor_select_core #(
    parameter int MAX_AGENTS    = 64,
    parameter int MAX_NEIGHBORS = 8,
    parameter int COORD_BITS    = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wen,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [knn_sel_pkg::DIST_W-1:0] cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // agent_index, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, goal_x, goal_y, goal_z
    input  wire logic [((knn_sel_pkg::IDX_W + 9 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // kind
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // rel_pos_x, rel_pos_y, rel_pos_z, rel_vel_x, rel_vel_y, rel_vel_z, distance,
    // rel_goal_x, rel_goal_y, rel_goal_z
    output logic [knn_sel_pkg::OUT_TW-1:0]     m_tdata,
    // goal_shared
    output logic                               m_tuser,
    output logic                               m_tlast
);
    import knn_sel_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int AW   = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
    localparam int NW   = $clog2(MAX_AGENTS + 1);
    localparam int KW   = $clog2(MAX_NEIGHBORS + 1);
    localparam int RI   = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int EW   = 9 * CB;
    localparam int D2W  = 2 * CB + 4;
    localparam int RW   = D2W / 2;
    localparam int SW   = (RW > DIST_W) ? RW : DIST_W;
    localparam int CMPW = (D2W > RANGE2_W) ? D2W : RANGE2_W;
    localparam int RXW  = (CB + 1 > REL_W) ? CB + 1 : REL_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_EGO   = 4'd1;
    localparam logic [3:0] ST_EGOW  = 4'd2;
    localparam logic [3:0] ST_SCAN  = 4'd3;
    localparam logic [3:0] ST_DRAIN = 4'd4;
    localparam logic [3:0] ST_RES   = 4'd5;
    localparam logic [3:0] ST_RDW   = 4'd6;
    localparam logic [3:0] ST_SQRT  = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    // configuration
    logic [6:0]         active_reg;
    logic [3:0]         wanted_reg;
    logic               sharing_reg;
    logic [DIST_W-1:0]  range_reg;
    logic [RANGE2_W-1:0] range2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 7'd64;
            wanted_reg  <= 4'd4;
            sharing_reg <= 1'b0;
            range_reg   <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_ACTIVE:  active_reg  <= cfg_data[6:0];
                CFG_WANTED:  wanted_reg  <= cfg_data[3:0];
                CFG_SHARING: sharing_reg <= cfg_data[0];
                CFG_RANGE:   range_reg   <= cfg_data;
                default:     active_reg  <= active_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        range2_reg <= range_reg * range_reg;
    end

    logic [NW-1:0] n_eff;
    logic [KW-1:0] k_eff;

    assign n_eff = (32'(active_reg) > MAX_AGENTS) ? NW'(MAX_AGENTS) : NW'(active_reg);
    assign k_eff = (wanted_reg == 4'd0) ? KW'(1) :
                   (32'(wanted_reg) > MAX_NEIGHBORS) ? KW'(MAX_NEIGHBORS) : KW'(wanted_reg);

    // table
    logic [EW-1:0]  mem [MAX_AGENTS];
    logic [EW-1:0]  rdata_reg;
    logic [AW-1:0]  raddr;
    logic           s_acc;
    logic [IDX_W-1:0] in_idx;

    assign s_acc  = s_tvalid && s_tready;
    assign in_idx = s_tdata[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (s_acc && s_tuser == KIND_WRITE && 32'(in_idx) < MAX_AGENTS)
        begin
            mem[AW'(in_idx)] <= s_tdata[IDX_W +: EW];
        end
        rdata_reg <= mem[raddr];
    end

    // control
    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] ego_reg;
    logic [NW-1:0] scan_reg;
    logic [1:0]    drain_reg;
    logic [RI-1:0] r_reg;
    logic          p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg;
    logic [AW-1:0] p1_who_reg, p2_who_reg, p3_who_reg, p4_who_reg;

    logic [CB-1:0] ego_px_reg, ego_py_reg, ego_pz_reg;
    logic [CB-1:0] ego_vx_reg, ego_vy_reg, ego_vz_reg;

    logic                 cell_take  [MAX_NEIGHBORS];
    logic                 cell_valid [MAX_NEIGHBORS];
    logic [D2W-1:0]       cell_d2    [MAX_NEIGHBORS];
    logic [AW-1:0]        cell_who   [MAX_NEIGHBORS];
    knn_ctl_t             ctl;
    logic [D2W-1:0]       d2_reg;

    logic                 sq_start;
    logic                 sq_done;
    logic [RW-1:0]        sq_root;
    logic [SW-1:0]        root_w;

    logic                 last_res;

    assign last_res = (KW'(r_reg) == k_eff - 1'b1);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign ctl.clr  = (state_reg == ST_EGO);
    assign ctl.ins  = p4_v_reg;
    assign sq_start = (state_reg == ST_RDW);

    always_comb
    begin
        case (state_reg)
            ST_SCAN: raddr = scan_reg[AW-1:0];
            ST_RES:  raddr = cell_who[r_reg];
            default: raddr = ego_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc && s_tuser == KIND_QUERY && 32'(in_idx) < 32'(n_eff))
                begin
                    state_next = ST_EGO;
                end
            end
            ST_EGO:   state_next = ST_EGOW;
            ST_EGOW:  state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_reg == n_eff - 1'b1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg == 2'd3)
                begin
                    state_next = ST_RES;
                end
            end
            ST_RES:   state_next = cell_valid[r_reg] ? ST_RDW : ST_OUT;
            ST_RDW:   state_next = ST_SQRT;
            ST_SQRT:
            begin
                if (sq_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = last_res ? ST_IDLE : ST_RES;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            scan_reg  <= '0;
            drain_reg <= '0;
            r_reg     <= '0;
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            p3_v_reg  <= 1'b0;
            p4_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            p1_v_reg  <= (state_reg == ST_SCAN) && (scan_reg[AW-1:0] != ego_reg);
            p2_v_reg  <= p1_v_reg;
            p3_v_reg  <= p2_v_reg;
            p4_v_reg  <= p3_v_reg;
            if (state_reg == ST_EGO)
            begin
                scan_reg  <= '0;
                drain_reg <= '0;
                r_reg     <= '0;
            end
            if (state_reg == ST_SCAN)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (state_reg == ST_DRAIN)
            begin
                drain_reg <= drain_reg + 1'b1;
            end
            if (state_reg == ST_OUT && m_tready && !last_res)
            begin
                r_reg <= r_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            ego_reg <= AW'(in_idx);
        end
        if (state_reg == ST_EGOW)
        begin
            ego_px_reg <= rdata_reg[0*CB +: CB];
            ego_py_reg <= rdata_reg[1*CB +: CB];
            ego_pz_reg <= rdata_reg[2*CB +: CB];
            ego_vx_reg <= rdata_reg[3*CB +: CB];
            ego_vy_reg <= rdata_reg[4*CB +: CB];
            ego_vz_reg <= rdata_reg[5*CB +: CB];
        end
    end

    // distance pipeline: read, difference, square, sum
    logic signed [CB:0]     dx_reg, dy_reg, dz_reg;
    logic signed [2*CB+1:0] sx_reg, sy_reg, sz_reg;

    always_ff @(posedge clk)
    begin
        p1_who_reg <= scan_reg[AW-1:0];
        p2_who_reg <= p1_who_reg;
        p3_who_reg <= p2_who_reg;
        p4_who_reg <= p3_who_reg;
        dx_reg <= $signed({rdata_reg[1*CB-1], rdata_reg[0*CB +: CB]})
                - $signed({ego_px_reg[CB-1], ego_px_reg});
        dy_reg <= $signed({rdata_reg[2*CB-1], rdata_reg[1*CB +: CB]})
                - $signed({ego_py_reg[CB-1], ego_py_reg});
        dz_reg <= $signed({rdata_reg[3*CB-1], rdata_reg[2*CB +: CB]})
                - $signed({ego_pz_reg[CB-1], ego_pz_reg});
        sx_reg <= dx_reg * dx_reg;
        sy_reg <= dy_reg * dy_reg;
        sz_reg <= dz_reg * dz_reg;
        d2_reg <= D2W'($unsigned(sx_reg)) + D2W'($unsigned(sy_reg))
                + D2W'($unsigned(sz_reg));
    end

    // sorted chain of nearest candidates
    genvar g;
    generate
        for (g = 0; g < MAX_NEIGHBORS; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                knn_sel_cell #(.D2W(D2W), .AW(AW)) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctl        (ctl),
                    .new_d2     (d2_reg),
                    .new_who    (p4_who_reg),
                    .prev_take  (1'b0),
                    .prev_valid (1'b0),
                    .prev_d2    (d2_reg),
                    .prev_who   (p4_who_reg),
                    .take       (cell_take[g]),
                    .valid      (cell_valid[g]),
                    .d2         (cell_d2[g]),
                    .who        (cell_who[g])
                );
            end
            else
            begin : g_body
                knn_sel_cell #(.D2W(D2W), .AW(AW)) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctl        (ctl),
                    .new_d2     (d2_reg),
                    .new_who    (p4_who_reg),
                    .prev_take  (cell_take[g-1]),
                    .prev_valid (cell_valid[g-1]),
                    .prev_d2    (cell_d2[g-1]),
                    .prev_who   (cell_who[g-1]),
                    .take       (cell_take[g]),
                    .valid      (cell_valid[g]),
                    .d2         (cell_d2[g]),
                    .who        (cell_who[g])
                );
            end
        end
    endgenerate

    knn_sel_isqrt #(.D2W(D2W)) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (cell_d2[r_reg]),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign root_w = SW'(sq_root);

    // result assembly
    logic signed [RXW-1:0] n_px, n_py, n_pz, n_vx, n_vy, n_vz, n_gx, n_gy, n_gz;
    logic signed [RXW-1:0] e_px, e_py, e_pz, e_vx, e_vy, e_vz;
    logic signed [RXW-1:0] rel_px, rel_py, rel_pz, rel_vx, rel_vy, rel_vz;
    logic signed [RXW-1:0] rel_gx, rel_gy, rel_gz;
    logic                  share_ok;

    assign n_px = $signed(rdata_reg[0*CB +: CB]);
    assign n_py = $signed(rdata_reg[1*CB +: CB]);
    assign n_pz = $signed(rdata_reg[2*CB +: CB]);
    assign n_vx = $signed(rdata_reg[3*CB +: CB]);
    assign n_vy = $signed(rdata_reg[4*CB +: CB]);
    assign n_vz = $signed(rdata_reg[5*CB +: CB]);
    assign n_gx = $signed(rdata_reg[6*CB +: CB]);
    assign n_gy = $signed(rdata_reg[7*CB +: CB]);
    assign n_gz = $signed(rdata_reg[8*CB +: CB]);
    assign e_px = $signed(ego_px_reg);
    assign e_py = $signed(ego_py_reg);
    assign e_pz = $signed(ego_pz_reg);
    assign e_vx = $signed(ego_vx_reg);
    assign e_vy = $signed(ego_vy_reg);
    assign e_vz = $signed(ego_vz_reg);
    assign rel_px = n_px - e_px;
    assign rel_py = n_py - e_py;
    assign rel_pz = n_pz - e_pz;
    assign rel_vx = n_vx - e_vx;
    assign rel_vy = n_vy - e_vy;
    assign rel_vz = n_vz - e_vz;
    assign rel_gx = n_gx - e_px;
    assign rel_gy = n_gy - e_py;
    assign rel_gz = n_gz - e_pz;
    assign share_ok = sharing_reg && (CMPW'(cell_d2[r_reg]) <= CMPW'(range2_reg));

    logic [REL_W-1:0]  o_px_reg, o_py_reg, o_pz_reg, o_vx_reg, o_vy_reg, o_vz_reg;
    logic [REL_W-1:0]  o_gx_reg, o_gy_reg, o_gz_reg;
    logic [DIST_W-1:0] o_dist_reg;
    logic              o_shared_reg;
    logic              o_last_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RES && !cell_valid[r_reg])
        begin
            o_px_reg     <= '0;
            o_py_reg     <= '0;
            o_pz_reg     <= '0;
            o_vx_reg     <= '0;
            o_vy_reg     <= '0;
            o_vz_reg     <= '0;
            o_gx_reg     <= '0;
            o_gy_reg     <= '0;
            o_gz_reg     <= '0;
            o_dist_reg   <= PAD_DISTANCE;
            o_shared_reg <= sharing_reg;
        end
        if (state_reg == ST_RES)
        begin
            o_last_reg <= last_res;
        end
        if (state_reg == ST_RDW)
        begin
            o_px_reg     <= rel_px[REL_W-1:0];
            o_py_reg     <= rel_py[REL_W-1:0];
            o_pz_reg     <= rel_pz[REL_W-1:0];
            o_vx_reg     <= rel_vx[REL_W-1:0];
            o_vy_reg     <= rel_vy[REL_W-1:0];
            o_vz_reg     <= rel_vz[REL_W-1:0];
            o_gx_reg     <= share_ok ? rel_gx[REL_W-1:0] : '0;
            o_gy_reg     <= share_ok ? rel_gy[REL_W-1:0] : '0;
            o_gz_reg     <= share_ok ? rel_gz[REL_W-1:0] : '0;
            o_shared_reg <= share_ok;
        end
        if (state_reg == ST_SQRT && sq_done)
        begin
            o_dist_reg <= (root_w > SW'(DIST_MAX)) ? DIST_MAX : root_w[DIST_W-1:0];
        end
    end

    assign m_tdata = OUT_TW'({o_gz_reg, o_gy_reg, o_gx_reg, o_dist_reg,
                              o_vz_reg, o_vy_reg, o_vx_reg, o_pz_reg, o_py_reg, o_px_reg});
    assign m_tuser = o_shared_reg;
    assign m_tlast = o_last_reg;

endmodule
`default_nettype wire

@@ test/k_nearest_neighbor_select_core_tb.sv @@
`default_nettype none
module k_nearest_neighbor_select_core_tb;
    import knn_sel_pkg::*;

    localparam int AGENTS     = 64;
    localparam int MAX_K      = 8;
    localparam int CB         = 24;
    localparam int IN_TW      = ((IDX_W + 9 * CB + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD  = 1500;

    typedef struct packed {
        logic             kind;
        logic [5:0]       idx;
        logic [8:0][23:0] v;
    } request_t;

    typedef struct packed {
        logic [OUT_TW-1:0] data;
        logic              shared;
        logic              last;
    } neighbor_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wen;
    logic [1:0]        cfg_index;
    logic [DIST_W-1:0] cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_TW-1:0]  s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_TW-1:0] m_tdata;
    logic              m_tuser;
    logic              m_tlast;

    k_nearest_neighbor_select_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // agent table shadow: pos xyz, vel xyz, goal xyz
    logic signed [23:0] agent_tbl[9][AGENTS];
    logic [6:0]         active_cnt;
    logic [3:0]         wanted_cnt;
    logic               share_en;
    logic [25:0]        share_rng;

    request_t  request_q[$];
    neighbor_t neighbor_q[$];
    int        mismatches;
    int        send_gap;
    int        recv_gap;
    int        hold_cnt;
    int        idle_cycles;
    bit        calm;
    bit        long_hold_go;
    bit        long_hold_done;

    function automatic void add_request(request_t rq);
        request_q.insert(request_q.size(), rq);
    endfunction

    function automatic void add_neighbor(neighbor_t nb);
        neighbor_q.insert(neighbor_q.size(), nb);
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (calm || sel < 45)
            return 0;
        else if (sel < 88)
            return $urandom_range(1, 3);
        else if (sel < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned d);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int b = 26; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if (c * c <= d)
                r = c;
        end
        return r;
    endfunction

    function automatic void predict_neighbors(int ego);
        longint unsigned dsq[AGENTS];
        bit              taken[AGENTS];
        int              n;
        int              k;
        int              best;
        longint          dv;
        neighbor_t       nb;
        longint unsigned root_val;
        n = (active_cnt > AGENTS) ? AGENTS : int'(active_cnt);
        if (ego >= n)
            return;
        k = (wanted_cnt == 0) ? 1 : ((wanted_cnt > MAX_K) ? MAX_K : int'(wanted_cnt));
        for (int i = 0; i < AGENTS; i++)
        begin
            taken[i] = 0;
            dsq[i] = 0;
            if (i < n && i != ego)
                for (int a = 0; a < 3; a++)
                begin
                    dv = longint'(agent_tbl[a][i]) - longint'(agent_tbl[a][ego]);
                    dsq[i] += longint'(dv * dv);
                end
        end
        for (int r = 0; r < k; r++)
        begin
            best = -1;
            for (int i = 0; i < n; i++)
                if (i != ego && !taken[i] && (best < 0 || dsq[i] < dsq[best]))
                    best = i;
            nb = '0;
            nb.last = (r == k - 1);
            if (best < 0)
            begin
                nb.data[150 +: 26] = PAD_DISTANCE;
                nb.shared = share_en;
            end
            else
            begin
                taken[best] = 1;
                for (int f = 0; f < 6; f++)
                    nb.data[f * 25 +: 25] = 25'(longint'(agent_tbl[f][best])
                                                - longint'(agent_tbl[f][ego]));
                root_val = int_sqrt(dsq[best]);
                nb.data[150 +: 26] = (root_val > 64'(DIST_MAX)) ? DIST_MAX : 26'(root_val);
                if (share_en && longint'(share_rng) * longint'(share_rng) >= dsq[best])
                begin
                    nb.shared = 1'b1;
                    for (int g = 0; g < 3; g++)
                        nb.data[176 + g * 25 +: 25] = 25'(longint'(agent_tbl[6 + g][best])
                                                         - longint'(agent_tbl[g][ego]));
                end
            end
            add_neighbor(nb);
        end
    endfunction

    function automatic void apply_request(request_t rq);
        if (rq.kind == KIND_WRITE)
        begin
            for (int f = 0; f < 9; f++)
                agent_tbl[f][rq.idx] = rq.v[f];
        end
        else
            predict_neighbors(int'(rq.idx));
    endfunction

    function automatic void check_neighbor(neighbor_t nb);
        string             names[10];
        int                offs[10];
        int                wid;
        bit                bad;
        logic [OUT_TW-1:0] mask;
        logic [OUT_TW-1:0] exp_f;
        logic [OUT_TW-1:0] act_f;
        names = '{"rel_pos_x", "rel_pos_y", "rel_pos_z", "rel_vel_x", "rel_vel_y",
                  "rel_vel_z", "distance", "rel_goal_x", "rel_goal_y", "rel_goal_z"};
        offs  = '{0, 25, 50, 75, 100, 125, 150, 176, 201, 226};
        bad = 0;
        for (int f = 0; f < 10; f++)
        begin
            wid = (f == 6) ? 26 : 25;
            mask  = (OUT_TW'(1) << wid) - 1'b1;
            exp_f = (nb.data >> offs[f]) & mask;
            act_f = (m_tdata >> offs[f]) & mask;
            if (act_f !== exp_f)
            begin
                bad = 1;
                if (mismatches < 10)
                    $display("%s mismatch: expected %h actual %h", names[f],
                             exp_f[25:0], act_f[25:0]);
            end
        end
        if (m_tuser !== nb.shared)
        begin
            bad = 1;
            if (mismatches < 10)
                $display("goal_shared mismatch: expected %b actual %b", nb.shared, m_tuser);
        end
        if (m_tlast !== nb.last)
        begin
            bad = 1;
            if (mismatches < 10)
                $display("last mismatch: expected %b actual %b", nb.last, m_tlast);
        end
        if (bad)
            mismatches++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_request(request_q[0]);
                request_q.pop_front();
                send_gap = pick_gap();
            end
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (request_q.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, request_q[0].v, request_q[0].idx};
                s_tuser  <= request_q[0].kind;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt <= 0;
            long_hold_done <= 0;
        end
        else if (long_hold_go && !long_hold_done)
        begin
            hold_cnt <= LONG_HOLD;
            long_hold_done <= 1;
        end
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                recv_gap = pick_gap();
                if (neighbor_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: data=%h shared=%b last=%b",
                                 m_tdata, m_tuser, m_tlast);
                end
                else
                begin
                    check_neighbor(neighbor_q[0]);
                    neighbor_q.pop_front();
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= (hold_cnt == 0) && !(long_hold_go && !long_hold_done);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [23:0] rand_coord(int spread);
        case ($urandom_range(0, 9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2, 3, 4, 5: return 24'($urandom_range(0, 2 * spread) - spread);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic request_t make_write(int idx, int spread);
        request_t rq;
        rq.kind = KIND_WRITE;
        rq.idx  = 6'(idx);
        for (int f = 0; f < 9; f++)
            rq.v[f] = rand_coord(spread);
        return rq;
    endfunction

    function automatic request_t make_query(int idx);
        request_t rq;
        rq.kind = KIND_QUERY;
        rq.idx  = 6'(idx);
        for (int f = 0; f < 9; f++)
            rq.v[f] = 24'($urandom);
        return rq;
    endfunction

    task automatic write_reg(logic [1:0] index, logic [25:0] value);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        case (index)
            CFG_ACTIVE:  active_cnt = value[6:0];
            CFG_WANTED:  wanted_cnt = value[3:0];
            CFG_SHARING: share_en   = value[0];
            default:     share_rng  = value;
        endcase
    endtask

    task automatic drain();
        wait (request_q.size() == 0 && !s_tvalid);
        wait (neighbor_q.size() == 0);
        repeat (120) @(posedge clk);
    endtask

    task automatic set_config(int act, int want, int shr, int rng);
        write_reg(CFG_ACTIVE, 26'(act));
        write_reg(CFG_WANTED, 26'(want));
        write_reg(CFG_SHARING, 26'(shr));
        write_reg(CFG_RANGE, 26'(rng));
    endtask

    initial
    begin
        request_t rq;
        int       act;
        int       spread;
        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        idle_cycles = 0;
        calm = 0;
        long_hold_go = 0;
        active_cnt = 7'd64;
        wanted_cnt = 4'd4;
        share_en = 1'b0;
        share_rng = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // fill the table with defaults in force, extremes and a tie at 2 and 3
        for (int i = 0; i < AGENTS; i++)
        begin
            rq = make_write(i, 3000);
            if (i == 0)
                rq.v = {9{24'h7FFFFF}};
            else if (i == 1)
                rq.v = {9{24'h800000}};
            else if (i == 3)
                rq.v[2:0] = request_q[2].v[2:0];
            add_request(rq);
        end
        add_request(make_query(0));
        add_request(make_query(1));
        add_request(make_query(2));
        add_request(make_query(63));
        drain();

        set_config(0, 0, 1, 26'h3FFFFFF);
        add_request(make_query(0));
        drain();
        set_config(1, 15, 1, 0);
        add_request(make_query(0));
        add_request(make_query(5));
        drain();
        set_config(2, 8, 1, 26'h3FFFFFF);
        add_request(make_query(0));
        add_request(make_query(1));
        drain();
        set_config(127, 8, 1, 0);
        add_request(make_query(3));
        add_request(make_query(2));
        drain();
        set_config(10, 1, 0, 500);
        add_request(make_query(9));
        add_request(make_query(40));
        drain();

        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: act = 64;
                1: act = 2;
                default: act = $urandom_range(0, 127);
            endcase
            spread = (ph % 2) ? 4000 : 400000;
            set_config(act, (ph == 2) ? 8 : $urandom_range(0, 15), $urandom_range(0, 1),
                       (ph == 3) ? 26'h3FFFFFF : $urandom_range(0, 6000));
            calm = (ph == 4);
            if (ph == 5)
                long_hold_go = 1;
            for (int n = 0; n < 38; n++)
            begin
                if ($urandom_range(0, 99) < 55)
                    add_request(make_query($urandom_range(0, 63)));
                else
                    add_request(make_write($urandom_range(0, 63), spread));
            end
            drain();
        end

        if (neighbor_q.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
rtl/core/knn_sel_pkg.sv
rtl/core/knn_sel_cell.sv
rtl/core/knn_sel_isqrt.sv
rtl/core/k_nearest_neighbor_select_core.sv
test/k_nearest_neighbor_select_core_tb.sv
